### sv/tfv_pkg.sv
`default_nettype none

package tfv_pkg;

   // Longest line that can still be accepted, in bytes.
   localparam int MAX_LINE_BYTES = 1024;
   // The line length counter saturates one above the limit.
   localparam int LINE_LEN_W = $clog2(MAX_LINE_BYTES + 2);

   // Frame kinds reported on the result channel.
   localparam logic [1:0] KIND_HELLO   = 2'd0;
   localparam logic [1:0] KIND_STATE   = 2'd1;
   localparam logic [1:0] KIND_GOODBYE = 2'd2;

   // Bit positions in the keyword candidate set.
   localparam int KW_HELLO   = 0;
   localparam int KW_STATE   = 1;
   localparam int KW_GOODBYE = 2;

   // Bit positions in the state word candidate set.
   localparam int SW_SAFE      = 0;
   localparam int SW_SENSITIVE = 1;

   // Token texts, left aligned in nine byte slots.
   localparam logic [71:0] PREFIX_TEXT    = {32'h5047_2F31, 40'h0};
   localparam logic [71:0] HELLO_TEXT     = {"HELLO", 32'h0};
   localparam logic [71:0] STATE_TEXT     = {"STATE", 32'h0};
   localparam logic [71:0] GOODBYE_TEXT   = {"GOODBYE", 16'h0};
   localparam logic [71:0] SAFE_TEXT      = {"SAFE", 40'h0};
   localparam logic [71:0] SENSITIVE_TEXT = "SENSITIVE";

   localparam logic [3:0] PREFIX_LEN    = 4'd4;
   localparam logic [3:0] HELLO_LEN     = 4'd5;
   localparam logic [3:0] STATE_LEN     = 4'd5;
   localparam logic [3:0] GOODBYE_LEN   = 4'd7;
   localparam logic [3:0] SAFE_LEN      = 4'd4;
   localparam logic [3:0] SENSITIVE_LEN = 4'd9;

   // Canonical UUID layout: 36 characters with dashes at fixed places.
   localparam logic [5:0] UUID_LEN   = 6'd36;
   localparam logic [5:0] UUID_DASH0 = 6'd8;
   localparam logic [5:0] UUID_DASH1 = 6'd13;
   localparam logic [5:0] UUID_DASH2 = 6'd18;
   localparam logic [5:0] UUID_DASH3 = 6'd23;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;

   // One result item.
   typedef struct packed {
      logic        frame_ok;
      logic [1:0]  frame_kind;
      logic [63:0] sequence_number;
      logic        is_sensitive;
      logic [63:0] id_upper;
      logic [63:0] id_lower;
   } result_type;

endpackage

`default_nettype wire

### sv/tfv_line_check.sv
`default_nettype none

module tfv_line_check (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         char_byte,
   input  wire logic               end_of_line,
   output tfv_pkg::result_type     result
);

   // Per-line parse state.
   typedef struct packed {
      logic [tfv_pkg::LINE_LEN_W-1:0] len;
      logic [2:0]                     tok_num;
      logic [5:0]                     tok_off;
      logic                           bad;
      logic                           prev_space;
      logic [2:0]                     kw;
      logic [63:0]                    seq;
      logic [63:0]                    uuid_hi;
      logic [63:0]                    uuid_lo;
      logic [1:0]                     sw;
   } line_state_type;

   line_state_type state_ff;
   line_state_type state_in;
   line_state_type work;

   // True when the byte matches the text at this offset and the offset is inside the text.
   function automatic logic text_hit(logic [71:0] text, logic [3:0] len,
                                     logic [5:0] off, logic [7:0] c);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < 9; i++) begin
         if (off == 6'(i) && 4'(i) < len) begin
            hit = (text[71-8*i -: 8] == c);
         end
      end
      return hit;
   endfunction

   // Hex digit decode: valid flag in the top bit, value below.
   function automatic logic [4:0] hex_decode(logic [7:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Consume one non-space byte of the current token.
   function automatic line_state_type take_char(line_state_type s, logic [7:0] c);
      line_state_type t;
      logic [4:0]     hx;
      logic [67:0]    wide;
      t = s;
      hx = hex_decode(c);
      wide = ({4'b0, s.seq} << 3) + ({4'b0, s.seq} << 1) + {64'b0, c[3:0]};
      case (s.tok_num)
         3'd0: begin
            if (!text_hit(tfv_pkg::PREFIX_TEXT, tfv_pkg::PREFIX_LEN, s.tok_off, c)) begin
               t.bad = 1'b1;
            end
         end
         3'd1: begin
            if (s.tok_off == 6'd0) begin
               t.kw = 3'b111;
            end
            t.kw[tfv_pkg::KW_HELLO] = t.kw[tfv_pkg::KW_HELLO] &
               text_hit(tfv_pkg::HELLO_TEXT, tfv_pkg::HELLO_LEN, s.tok_off, c);
            t.kw[tfv_pkg::KW_STATE] = t.kw[tfv_pkg::KW_STATE] &
               text_hit(tfv_pkg::STATE_TEXT, tfv_pkg::STATE_LEN, s.tok_off, c);
            t.kw[tfv_pkg::KW_GOODBYE] = t.kw[tfv_pkg::KW_GOODBYE] &
               text_hit(tfv_pkg::GOODBYE_TEXT, tfv_pkg::GOODBYE_LEN, s.tok_off, c);
         end
         3'd2: begin
            if (s.kw[tfv_pkg::KW_HELLO]) begin
               if (s.tok_off >= tfv_pkg::UUID_LEN) begin
                  t.bad = 1'b1;
               end else if (s.tok_off == tfv_pkg::UUID_DASH0 ||
                            s.tok_off == tfv_pkg::UUID_DASH1 ||
                            s.tok_off == tfv_pkg::UUID_DASH2 ||
                            s.tok_off == tfv_pkg::UUID_DASH3) begin
                  if (c != tfv_pkg::CHAR_DASH) begin
                     t.bad = 1'b1;
                  end
               end else if (!hx[4]) begin
                  t.bad = 1'b1;
               end else begin
                  t.uuid_hi = {s.uuid_hi[59:0], s.uuid_lo[63:60]};
                  t.uuid_lo = {s.uuid_lo[59:0], hx[3:0]};
               end
            end else if (s.kw[tfv_pkg::KW_STATE]) begin
               // Decimal digit: times ten plus digit, rejected if it no longer fits.
               if (c < 8'h30 || c > 8'h39) begin
                  t.bad = 1'b1;
               end else if (wide[67:64] != 4'd0) begin
                  t.bad = 1'b1;
               end else begin
                  t.seq = wide[63:0];
               end
            end else begin
               t.bad = 1'b1;
            end
         end
         3'd3: begin
            if (s.tok_off == 6'd0) begin
               t.sw = 2'b11;
            end
            t.sw[tfv_pkg::SW_SAFE] = t.sw[tfv_pkg::SW_SAFE] &
               text_hit(tfv_pkg::SAFE_TEXT, tfv_pkg::SAFE_LEN, s.tok_off, c);
            t.sw[tfv_pkg::SW_SENSITIVE] = t.sw[tfv_pkg::SW_SENSITIVE] &
               text_hit(tfv_pkg::SENSITIVE_TEXT, tfv_pkg::SENSITIVE_LEN, s.tok_off, c);
         end
         default: begin
            t.bad = 1'b1;
         end
      endcase
      if (s.tok_off != 6'd63) begin
         t.tok_off = s.tok_off + 6'd1;
      end
      return t;
   endfunction

   // Close the current token and check its length against its role.
   function automatic line_state_type finish_token(line_state_type s);
      line_state_type t;
      t = s;
      case (s.tok_num)
         3'd0: begin
            if (s.tok_off != 6'(tfv_pkg::PREFIX_LEN)) begin
               t.bad = 1'b1;
            end
         end
         3'd1: begin
            if (s.tok_off != 6'(tfv_pkg::HELLO_LEN)) begin
               t.kw[tfv_pkg::KW_HELLO] = 1'b0;
               t.kw[tfv_pkg::KW_STATE] = 1'b0;
            end
            if (s.tok_off != 6'(tfv_pkg::GOODBYE_LEN)) begin
               t.kw[tfv_pkg::KW_GOODBYE] = 1'b0;
            end
            if (t.kw == 3'b000) begin
               t.bad = 1'b1;
            end
         end
         3'd2: begin
            if (s.kw[tfv_pkg::KW_HELLO]) begin
               if (s.tok_off != tfv_pkg::UUID_LEN) begin
                  t.bad = 1'b1;
               end
            end else if (!s.kw[tfv_pkg::KW_STATE]) begin
               t.bad = 1'b1;
            end
         end
         3'd3: begin
            if (s.tok_off != 6'(tfv_pkg::SAFE_LEN)) begin
               t.sw[tfv_pkg::SW_SAFE] = 1'b0;
            end
            if (s.tok_off != 6'(tfv_pkg::SENSITIVE_LEN)) begin
               t.sw[tfv_pkg::SW_SENSITIVE] = 1'b0;
            end
            if (!s.kw[tfv_pkg::KW_STATE] || t.sw == 2'b00) begin
               t.bad = 1'b1;
            end
         end
         default: begin
            t.bad = 1'b1;
         end
      endcase
      if (s.tok_num != 3'd7) begin
         t.tok_num = s.tok_num + 3'd1;
      end
      t.tok_off = 6'd0;
      return t;
   endfunction

   // Per-byte update, and the verdict on the line's last byte.
   always_comb begin
      work = state_ff;
      result = '0;

      if (state_ff.len <= tfv_pkg::LINE_LEN_W'(tfv_pkg::MAX_LINE_BYTES)) begin
         work.len = state_ff.len + tfv_pkg::LINE_LEN_W'(1);
      end
      if (work.len > tfv_pkg::LINE_LEN_W'(tfv_pkg::MAX_LINE_BYTES)) begin
         work.bad = 1'b1;
      end

      if (char_byte == tfv_pkg::CHAR_SPACE) begin
         if (work.tok_off == 6'd0) begin
            work.bad = 1'b1;
         end else begin
            work = finish_token(work);
         end
         work.prev_space = 1'b1;
      end else begin
         work = take_char(work, char_byte);
         work.prev_space = 1'b0;
      end

      if (end_of_line) begin
         if (work.prev_space || char_byte == tfv_pkg::CHAR_CR) begin
            work.bad = 1'b1;
         end
         if (!work.prev_space) begin
            work = finish_token(work);
         end
         if (!work.bad) begin
            if (work.kw[tfv_pkg::KW_HELLO] && work.tok_num == 3'd3) begin
               result.frame_ok = 1'b1;
               result.frame_kind = tfv_pkg::KIND_HELLO;
               result.id_upper = work.uuid_hi;
               result.id_lower = work.uuid_lo;
            end else if (work.kw[tfv_pkg::KW_STATE] && work.tok_num == 3'd4) begin
               result.frame_ok = 1'b1;
               result.frame_kind = tfv_pkg::KIND_STATE;
               result.sequence_number = work.seq;
               result.is_sensitive = work.sw[tfv_pkg::SW_SENSITIVE];
            end else if (work.kw[tfv_pkg::KW_GOODBYE] && work.tok_num == 3'd2) begin
               result.frame_ok = 1'b1;
               result.frame_kind = tfv_pkg::KIND_GOODBYE;
            end
         end
      end

      // Every line starts from a clean state.
      state_in = end_of_line ? '0 : work;
   end

   // Parse state advances once per consumed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### sv/text_frame_validator.sv
`default_nettype none

// Line frame validator. Bytes of one text line enter one item per clock on
// the req_ channel, with req_end_of_line set on the last byte; only that byte
// produces a result item on the rsp_ channel, telling whether the whole line
// is a well formed frame and, if so, its kind and its decoded sequence number
// or 128-bit client id. The block sustains one byte per cycle: each byte sits
// in an input register while the combinational parse update (token match,
// hex shift, multiply by ten with overflow check) runs; the verdict lands in a
// result register, so a last byte passes the input register, then the result
// register, before its result is offered on rsp_valid. Input is stalled only
// while a finished result waits and a further last byte is ready to be judged.
module text_frame_validator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_end_of_line,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_frame_ok,
   output logic [1:0]       rsp_frame_kind,
   output logic [63:0]      rsp_sequence_number,
   output logic             rsp_is_sensitive,
   output logic [63:0]      rsp_id_upper,
   output logic [63:0]      rsp_id_lower
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                in_eol_ff;
   logic                rsp_valid_ff;
   tfv_pkg::result_type rsp_ff;
   tfv_pkg::result_type verdict;
   logic                step;

   // A held byte moves on unless it would produce a result with no room for it.
   assign step = in_valid_ff && (!in_eol_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   tfv_line_check u_line_check (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .char_byte   (in_byte_ff),
      .end_of_line (in_eol_ff),
      .result      (verdict)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_byte_ff <= req_char_byte;
         in_eol_ff <= req_end_of_line;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && in_eol_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step && in_eol_ff) begin
         rsp_ff <= verdict;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_ok        = rsp_ff.frame_ok;
   assign rsp_frame_kind      = rsp_ff.frame_kind;
   assign rsp_sequence_number = rsp_ff.sequence_number;
   assign rsp_is_sensitive    = rsp_ff.is_sensitive;
   assign rsp_id_upper        = rsp_ff.id_upper;
   assign rsp_id_lower        = rsp_ff.id_lower;

`ifndef SYNTHESIS
   // A rejected line carries all-zero fields.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.frame_ok |->
         rsp_ff.frame_kind == 2'd0 && rsp_ff.sequence_number == 64'd0 &&
         !rsp_ff.is_sensitive && rsp_ff.id_upper == 64'd0 && rsp_ff.id_lower == 64'd0)
      else $error("rejected line has nonzero fields");

   // Only the three frame kinds are ever reported.
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.frame_kind != 2'd3)
      else $error("illegal frame kind");

   // A hello frame carries no sequence or sensitivity.
   a_hello_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_kind == tfv_pkg::KIND_HELLO |->
         rsp_ff.sequence_number == 64'd0 && !rsp_ff.is_sensitive)
      else $error("hello frame with state fields");

   // A byte that is not the last of its line never creates a result.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_ready) && !(step && in_eol_ff) |=> !rsp_valid_ff)
      else $error("result without a last byte");
`endif

endmodule

`default_nettype wire
